@@ rtl/pemon_pkg.sv @@
// ============================================================================
// pemon_pkg
// Shared types, codes and pattern constants of the PMIC error pattern monitor.
// ============================================================================
package pemon_pkg;

    localparam int NumTypes     = 17;
    localparam int NumBytes     = 7;
    localparam int DimmW        = 4;
    localparam int TypeW        = 5;
    localparam int DefDimmCount = 12;

    // Error types of the critical class: 0-4, 6-10 and 16.
    localparam logic [NumTypes-1:0] CriticalMask = 17'h107DF;

    // Status bytes in the order R05, R06, R08, R09, R0A, R0B, R33.
    typedef logic [0:NumBytes-1][7:0] t_status_bytes;
    typedef logic [NumTypes-1:0]      t_flags;

    localparam t_status_bytes ErrPattern [NumTypes] = '{
        '{8'h02, 8'h08, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h02, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h02, 8'h02, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h02, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h04, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h00, 8'h00, 8'h02, 8'h00, 8'h02, 8'h00, 8'h00},
        '{8'h02, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h02, 8'h40, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h02, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h02, 8'h10, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h08},
        '{8'h00, 8'h00, 8'h00, 8'h10, 8'h02, 8'h00, 8'h00},
        '{8'h00, 8'h00, 8'h00, 8'h80, 8'h02, 8'h00, 8'h00},
        '{8'h00, 8'h00, 8'h00, 8'h20, 8'h02, 8'h00, 8'h00},
        '{8'h00, 8'h00, 8'h00, 8'h0F, 8'h02, 8'h00, 8'h00},
        '{8'h00, 8'h00, 8'h00, 8'h00, 8'h02, 8'hF0, 8'h00},
        '{8'h00, 8'h00, 8'h40, 8'h00, 8'h00, 8'h00, 8'h00}
    };

    typedef enum logic {
        CMD_CHECK = 1'b0,
        CMD_SET   = 1'b1
    } t_command;

    typedef enum logic {
        KIND_EVENT   = 1'b0,
        KIND_SUMMARY = 1'b1
    } t_kind;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_BAD_DIMM = 2'd1,
        STAT_BAD_TYPE = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MATCH,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic             command;
        logic [DimmW-1:0] dimm;
        logic [TypeW-1:0] force_type;
        logic [7:0]       reg05_status;
        logic [7:0]       reg06_status;
        logic [7:0]       reg08_status;
        logic [7:0]       reg09_status;
        logic [7:0]       reg0a_status;
        logic [7:0]       reg0b_status;
        logic [7:0]       reg33_status;
        logic             bytes_complete;
    } t_in_item;

    typedef struct packed {
        logic             kind;
        logic [DimmW-1:0] event_dimm;
        logic [TypeW-1:0] evt_type;
        logic             any_match;
        logic             critical_set;
        logic [1:0]       status;
        logic             last;
    } t_out_item;

    // What the merge stage hands back to the sequencer.
    typedef struct packed {
        t_flags matched;
        t_flags fresh;
        logic   any;
        logic   crit;
    } t_merge;

endpackage

@@ rtl/pmic_error_pattern_monitor_core.sv @@
// ============================================================================
// pmic_error_pattern_monitor_core
// Latches PMIC error flags per DIMM and reports new errors and summaries.
// ============================================================================
//
//  Channel | Direction | Handshake                     | Payload
//  --------+-----------+-------------------------------+--------------------
//  in      | to core   | i_in_valid / o_in_stall       | i_in_data  (t_in_item)
//  out     | from core | o_out_valid / i_out_stall     | o_out_data (t_out_item)
//
//  An item is captured first; then the 17 matcher lanes and the merge stage
//  evaluate it and the flag table is updated; then its N results (1 to 18)
//  leave one per cycle through the single output register while the output
//  is not stalled.
//  i_rst_n is synchronous and clears all flags and the control state at once.
//  The core takes a new transfer as soon as the last result of the previous
//  item sits in the output register, even while that result is still stalled.
//
// ============================================================================
module pmic_error_pattern_monitor_core #(
    parameter int DIMM_COUNT = pemon_pkg::DefDimmCount
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  pemon_pkg::t_in_item  i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output pemon_pkg::t_out_item o_out_data
);
    import pemon_pkg::*;

    // Index width of the flag table; the dimm field is range checked first.
    localparam int IdxW = (DIMM_COUNT > 1) ? $clog2(DIMM_COUNT) : 1;

    // Control registers.
    t_state    r_state, n_state;
    logic      r_out_valid, n_out_valid;
    t_flags    r_pend, n_pend;

    // Payload registers.
    t_in_item  r_in, n_in;
    t_out_item r_final, n_final;
    t_out_item r_out, n_out;

    // Latched error flags, one row per DIMM slot.
    t_flags    r_flags [DIMM_COUNT];

    logic            flag_we;
    t_flags          flag_wdata;
    t_flags          cur_flags;
    logic [IdxW-1:0] dimm_idx;
    logic            dimm_ok;
    logic            type_ok;
    t_flags          set_mask;
    t_status_bytes   lane_bytes;
    t_flags          lane_hits;
    t_merge          mrg;
    logic            slot_free;
    t_flags          pend_lsb;
    logic [TypeW-1:0] pend_idx;

    assign dimm_ok  = ({1'b0, r_in.dimm} < (DimmW + 1)'(DIMM_COUNT));
    assign type_ok  = (r_in.force_type < TypeW'(NumTypes));
    assign dimm_idx = r_in.dimm[IdxW-1:0];
    assign cur_flags = r_flags[dimm_idx];
    assign set_mask  = t_flags'(1) << r_in.force_type;

    assign lane_bytes = {r_in.reg05_status, r_in.reg06_status, r_in.reg08_status,
                         r_in.reg09_status, r_in.reg0a_status, r_in.reg0b_status,
                         r_in.reg33_status};

    // One matcher lane per error type, all evaluated in the same cycle.
    for (genvar t = 0; t < NumTypes; t++) begin : g_lane
        pemon_lane u_lane (
            .i_status   (lane_bytes),
            .i_pattern  (ErrPattern[t]),
            .i_complete (r_in.bytes_complete),
            .o_hit      (lane_hits[t])
        );
    end

    pemon_merge u_merge (
        .i_hits  (lane_hits),
        .i_flags (cur_flags),
        .o_merge (mrg)
    );

    // Events leave in ascending error type: isolate the lowest pending bit.
    assign pend_lsb = r_pend & (~r_pend + t_flags'(1));

    always_comb begin
        pend_idx = '0;
        for (int i = 0; i < NumTypes; i++) begin
            if (pend_lsb[i]) begin
                pend_idx = pend_idx | TypeW'(i);
            end
        end
    end

    // The output register can take a result when empty or being drained.
    assign slot_free = !r_out_valid || !i_out_stall;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        n_state     = r_state;
        n_in        = r_in;
        n_pend      = r_pend;
        n_final     = r_final;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        flag_we     = 1'b0;
        flag_wdata  = cur_flags;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_in    = i_in_data;
                    n_state = S_MATCH;
                end
            end
            S_MATCH: begin
                // Build the closing result and update the flag row.
                n_pend             = '0;
                n_final            = '0;
                n_final.kind       = KIND_SUMMARY;
                n_final.event_dimm = r_in.dimm;
                n_final.status     = STAT_OK;
                n_final.last       = 1'b1;
                if (!dimm_ok) begin
                    n_final.status = STAT_BAD_DIMM;
                end else if (r_in.command == CMD_SET) begin
                    if (type_ok) begin
                        flag_we    = 1'b1;
                        flag_wdata = cur_flags | set_mask;
                    end else begin
                        n_final.status = STAT_BAD_TYPE;
                    end
                end else begin
                    flag_we              = 1'b1;
                    flag_wdata           = mrg.matched;
                    n_pend               = mrg.fresh;
                    n_final.any_match    = mrg.any;
                    n_final.critical_set = mrg.crit;
                end
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    if (|r_pend) begin
                        n_out            = '0;
                        n_out.kind       = KIND_EVENT;
                        n_out.event_dimm = r_in.dimm;
                        n_out.evt_type   = pend_idx;
                        n_out.status     = STAT_OK;
                        n_pend           = r_pend & ~pend_lsb;
                    end else begin
                        n_out   = r_final;
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_pend      <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_pend      <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in    <= n_in;
        r_final <= n_final;
        r_out   <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int d = 0; d < DIMM_COUNT; d++) begin
                r_flags[d] <= '0;
            end
        end else if (flag_we) begin
            r_flags[dimm_idx] <= flag_wdata;
        end
    end

endmodule

@@ rtl/pemon_lane.sv @@
// ============================================================================
// pemon_lane
// One matcher: hits on a complete byte set that holds every pattern bit.
// ============================================================================
module pemon_lane (
    input  pemon_pkg::t_status_bytes i_status,
    input  pemon_pkg::t_status_bytes i_pattern,
    input  logic                     i_complete,
    output logic                     o_hit
);
    import pemon_pkg::*;

    logic [NumBytes-1:0] byte_ok;

    always_comb begin
        for (int b = 0; b < NumBytes; b++) begin
            byte_ok[b] = ((i_status[b] & i_pattern[b]) == i_pattern[b]);
        end
    end

    assign o_hit = i_complete & (&byte_ok);

endmodule

@@ rtl/pemon_merge.sv @@
// ============================================================================
// pemon_merge
// Combines the lane hits with the stored flags of the addressed DIMM.
// ============================================================================
module pemon_merge (
    input  pemon_pkg::t_flags i_hits,
    input  pemon_pkg::t_flags i_flags,
    output pemon_pkg::t_merge o_merge
);
    import pemon_pkg::*;

    always_comb begin
        o_merge.matched = i_hits;
        // A hit is only reported when its flag was not already latched.
        o_merge.fresh   = i_hits & ~i_flags;
        o_merge.any     = |i_hits;
        o_merge.crit    = (|i_hits) & (|(i_hits & CriticalMask));
    end

endmodule

@@ tb/pemon_checker.sv @@
`timescale 1ns / 100ps
// ============================================================================
// pemon_checker
// Watches both channels of the error pattern monitor and checks each result
// transfer against a local model of the per-DIMM error flag table.
// ============================================================================
module pemon_checker #(
    parameter int DIMM_COUNT = pemon_pkg::DefDimmCount
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  pemon_pkg::t_in_item  i_in_data,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  pemon_pkg::t_out_item i_out_data,
    output int                   o_fail_count,
    output int                   o_pending
);
    import pemon_pkg::*;

    // Bit signatures of the 17 error types, bytes in the order R05 .. R33.
    localparam t_status_bytes ErrSignature [NumTypes] = '{
        '{8'h02, 8'h08, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h02, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h02, 8'h02, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h02, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h04, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h00, 8'h00, 8'h02, 8'h00, 8'h02, 8'h00, 8'h00},
        '{8'h02, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h02, 8'h40, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h02, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h02, 8'h10, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h08},
        '{8'h00, 8'h00, 8'h00, 8'h10, 8'h02, 8'h00, 8'h00},
        '{8'h00, 8'h00, 8'h00, 8'h80, 8'h02, 8'h00, 8'h00},
        '{8'h00, 8'h00, 8'h00, 8'h20, 8'h02, 8'h00, 8'h00},
        '{8'h00, 8'h00, 8'h00, 8'h0F, 8'h02, 8'h00, 8'h00},
        '{8'h00, 8'h00, 8'h00, 8'h00, 8'h02, 8'hF0, 8'h00},
        '{8'h00, 8'h00, 8'h40, 8'h00, 8'h00, 8'h00, 8'h00}
    };

    // Types 0-4, 6-10 and 16 are the ones that call for an MTP erase.
    localparam t_flags CriticalTypes = 17'h107DF;

    t_flags    flag_table [DIMM_COUNT];
    t_out_item expected_results [$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        o_fail_count++;
    endtask

    // Works out the results of one accepted item and updates the flag table.
    task automatic predict_results(input t_in_item item);
        t_status_bytes bytes;
        t_flags        hits;
        t_out_item     res;
        t_out_item     ev;
        bytes = {item.reg05_status, item.reg06_status, item.reg08_status,
                 item.reg09_status, item.reg0a_status, item.reg0b_status,
                 item.reg33_status};
        hits = '0;
        res = '0;
        res.kind = KIND_SUMMARY;
        res.event_dimm = item.dimm;
        res.status = STAT_OK;
        res.last = 1'b1;
        if (item.dimm >= DIMM_COUNT) begin
            res.status = STAT_BAD_DIMM;
            expected_results.push_back(res);
            return;
        end
        if (item.command == CMD_SET) begin
            if (item.force_type >= NumTypes) begin
                res.status = STAT_BAD_TYPE;
            end else begin
                flag_table[item.dimm][item.force_type] = 1'b1;
            end
            expected_results.push_back(res);
            return;
        end
        for (int t = 0; t < NumTypes; t++) begin
            if (item.bytes_complete && ((bytes & ErrSignature[t]) == ErrSignature[t])) begin
                hits[t] = 1'b1;
                if (!flag_table[item.dimm][t]) begin
                    ev = '0;
                    ev.kind = KIND_EVENT;
                    ev.event_dimm = item.dimm;
                    ev.evt_type = t[TypeW-1:0];
                    ev.status = STAT_OK;
                    expected_results.push_back(ev);
                end
            end
        end
        flag_table[item.dimm] = hits;
        res.any_match = |hits;
        res.critical_set = |(hits & CriticalTypes);
        expected_results.push_back(res);
    endtask

    task automatic compare_field(input string name, input logic [7:0] got_v,
                                 input logic [7:0] want_v, input logic [3:0] dimm);
        if (got_v !== want_v) begin
            report_mismatch($sformatf("dimm %0d %s: got %0h, expected %0h",
                                      dimm, name, got_v, want_v));
        end
    endtask

    task automatic check_result(input t_out_item got);
        t_out_item want;
        if (expected_results.size() == 0) begin
            report_mismatch($sformatf("result %h with nothing outstanding", got));
            return;
        end
        want = expected_results.pop_front();
        compare_field("kind", 8'(got.kind), 8'(want.kind), want.event_dimm);
        compare_field("event_dimm", 8'(got.event_dimm), 8'(want.event_dimm),
                      want.event_dimm);
        compare_field("evt_type", 8'(got.evt_type), 8'(want.evt_type), want.event_dimm);
        compare_field("any_match", 8'(got.any_match), 8'(want.any_match),
                      want.event_dimm);
        compare_field("critical_set", 8'(got.critical_set), 8'(want.critical_set),
                      want.event_dimm);
        compare_field("status", 8'(got.status), 8'(want.status), want.event_dimm);
        compare_field("last", 8'(got.last), 8'(want.last), want.event_dimm);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int d = 0; d < DIMM_COUNT; d++) begin
                flag_table[d] = '0;
            end
            expected_results.delete();
        end else begin
            // A result never belongs to the item taken in the same cycle,
            // so checking before predicting keeps the order right.
            if (i_out_valid && !i_out_stall) begin
                check_result(i_out_data);
            end
            if (i_in_valid && !i_in_stall) begin
                predict_results(i_in_data);
            end
        end
        o_pending = expected_results.size();
    end

endmodule

@@ tb/pmic_error_pattern_monitor_core_test.sv @@
`timescale 1ns / 100ps
// ============================================================================
// pmic_error_pattern_monitor_core_test
// Drives check and set items into the monitor core with random gaps and
// output stalls; a checker beside the core predicts and compares every result.
// ============================================================================
module pmic_error_pattern_monitor_core_test;

    import pemon_pkg::*;

    localparam int DIMMS        = DefDimmCount;
    // A generous bound: even every item giving 18 results, each held by a
    // long stall, finishes well inside it.
    localparam int CYCLE_LIMIT  = 1000000;
    // Idle cycles watched at the end, after every predicted result has come,
    // to catch any stray result.
    localparam int DRAIN_CYCLES = 40;
    localparam int ITEMS_PER_PHASE = 61;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    t_in_item  in_data = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_data;

    int fail_count;
    int pending;
    int cycle_count = 0;

    // Percentages of cycles in which the sender holds back or the receiver
    // stalls; each phase of the run sets its own pair.
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    // Last status byte set sent, reused so that flags which are already
    // latched see the same pattern again and raise no new event.
    t_status_bytes prev_bytes = '0;

    pmic_error_pattern_monitor_core #(
        .DIMM_COUNT(DIMMS)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data (out_data)
    );

    pemon_checker #(
        .DIMM_COUNT(DIMMS)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in_data   (in_data),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out_data  (out_data),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    always #2 i_clk = ~i_clk;

    // The receiver decides at each falling edge whether it stalls the next
    // rising edge. This is the only place that drives out_stall.
    always @(negedge i_clk) begin
        out_stall = ($urandom_range(99) < recv_stall_pct);
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic t_in_item make_item(input t_command cmd, input logic [3:0] dimm,
                                           input logic [4:0] etype,
                                           input t_status_bytes bytes,
                                           input logic complete);
        t_in_item item;
        item.command        = cmd;
        item.dimm           = dimm;
        item.force_type     = etype;
        item.reg05_status   = bytes[0];
        item.reg06_status   = bytes[1];
        item.reg08_status   = bytes[2];
        item.reg09_status   = bytes[3];
        item.reg0a_status   = bytes[4];
        item.reg0b_status   = bytes[5];
        item.reg33_status   = bytes[6];
        item.bytes_complete = complete;
        return item;
    endfunction

    // Presents one item and returns at the falling edge after its transfer.
    // Called at a falling edge; in_valid stays high from one item to the
    // next when no idle cycle falls between them.
    task automatic send_item(input t_in_item item);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid = 1'b0;
            @(negedge i_clk);
        end
        in_valid = 1'b1;
        in_data  = item;
        do begin
            @(posedge i_clk);
        end while (in_stall);
        @(negedge i_clk);
    endtask

    // Random items are mostly well-formed checks on a few busy DIMMs whose
    // bytes are built from real error signatures, so flags get latched,
    // held and cleared again. The rest is set commands, invalid slots and
    // types, incomplete byte sets and plain random bytes.
    task automatic random_item(output t_in_item item);
        t_status_bytes bytes;
        t_command      cmd;
        logic [3:0]    dimm;
        logic [4:0]    etype;
        logic          complete;
        int            pick;
        pick = $urandom_range(99);
        if (pick < 45) begin
            dimm = 4'($urandom_range(2));
        end else if (pick < 90) begin
            dimm = 4'($urandom_range(DIMMS - 1));
        end else begin
            dimm = 4'($urandom_range(15, DIMMS));
        end
        cmd = ($urandom_range(99) < 25) ? CMD_SET : CMD_CHECK;
        if (cmd == CMD_SET && $urandom_range(99) < 85) begin
            etype = 5'($urandom_range(NumTypes - 1));
        end else begin
            etype = 5'($urandom_range(31));
        end
        pick = $urandom_range(99);
        if (pick < 25) begin
            bytes = prev_bytes;
        end else if (pick < 37) begin
            for (int k = 0; k < NumBytes; k++) begin
                bytes[k] = 8'($urandom_range(255));
            end
        end else if (pick < 41) begin
            bytes = '1;
        end else begin
            bytes = '0;
            repeat ($urandom_range(3, 1)) begin
                bytes |= ErrPattern[$urandom_range(NumTypes - 1)];
            end
            // A stray bit now and then must not disturb the other matches.
            if ($urandom_range(99) < 30) begin
                bytes[$urandom_range(NumBytes - 1)][$urandom_range(7)] = 1'b1;
            end
        end
        prev_bytes = bytes;
        complete = ($urandom_range(99) < 90);
        item = make_item(cmd, dimm, etype, bytes, complete);
    endtask

    initial begin
        t_in_item item;
        int idle_by_phase [4];
        int stall_by_phase [4];
        idle_by_phase  = '{0, 85, 0, 14};
        stall_by_phase = '{0, 0, 85, 14};

        // Reset is held low at the start and released at a falling edge.
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed part, run without gaps or stalls.
        // No bits set: nothing matches on a clean slot.
        send_item(make_item(CMD_CHECK, 4'd0, 5'd0, '0, 1'b1));
        // All bits set: every error type is new, so 17 events and a summary.
        send_item(make_item(CMD_CHECK, 4'd0, 5'd0, '1, 1'b1));
        // Same bytes again: the flags are latched, only the summary comes.
        send_item(make_item(CMD_CHECK, 4'd0, 5'd31, '1, 1'b1));
        // Incomplete byte set: nothing can match and all flags drop.
        send_item(make_item(CMD_CHECK, 4'd0, 5'd0, '1, 1'b0));
        // Each signature on its own, one after another on one slot, so each
        // raises one event and clears the flag of the one before.
        for (int t = 0; t < NumTypes; t++) begin
            send_item(make_item(CMD_CHECK, 4'd1, 5'd0, ErrPattern[t], 1'b1));
        end
        // Forcing the highest valid type on the highest valid slot.
        send_item(make_item(CMD_SET, 4'(DIMMS - 1), 5'(NumTypes - 1), '0, 1'b1));
        // An invalid error type is refused.
        send_item(make_item(CMD_SET, 4'd2, 5'd31, '1, 1'b0));
        // An invalid slot on a set is reported before the error type.
        send_item(make_item(CMD_SET, 4'd15, 5'd31, '1, 1'b1));
        // An invalid slot on a check gives one status result.
        send_item(make_item(CMD_CHECK, 4'(DIMMS), 5'd0, '1, 1'b1));

        // Random part, one phase per idling pattern.
        for (int p = 0; p < 4; p++) begin
            send_idle_pct  = idle_by_phase[p];
            recv_stall_pct = stall_by_phase[p];
            repeat (ITEMS_PER_PHASE) begin
                random_item(item);
                send_item(item);
            end
        end
        in_valid = 1'b0;

        // Wait for every outstanding result, then watch a while for strays.
        while (pending != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
